@@ rtl/spt_pkg.sv @@
// Shared types and constants for the sample-phase tuning sweep unit.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps

package spt_pkg;

    // Phase count and window masks (bit 0 = centre, bits wrap modulo 8)
    localparam int unsigned PHASE_COUNT = 8;
    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_COUNT-1:0] WIDE_WINDOW = 8'hc7;
    localparam logic [PHASE_COUNT-1:0] NARROW_WINDOW = 8'h83;

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_BEGIN = 2'd0,
        KIND_TRIAL = 2'd1,
        KIND_SET   = 2'd2
    } kind_t;

    // One registered input item
    typedef struct packed {
        logic [1:0]         kind;
        logic               trial_passed;
        logic [PHASE_W-1:0] phase_value;
    } item_t;

    // Window search outcome
    typedef struct packed {
        logic               found;
        logic [PHASE_W-1:0] phase;
    } window_t;

endpackage

@@ rtl/spt_in_stage.sv @@
// Input register stage of the sample-phase tuning sweep unit.
// Depends on spt_pkg for the item type.
`timescale 1ns / 1ps

module spt_in_stage
    import spt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [0] trial_passed, [3:1] phase_value, [7:4] zero
    input  logic [1:0] s_tuser,   // [1:0] kind
    input  logic       out_free,  // result register can take an item this cycle
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  s_fire;

    // Accept when empty or when the held item moves on this cycle
    assign s_tready = !valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        if (s_fire)
        begin
            valid_next = 1'b1;
        end
        else if (out_free)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.kind         <= s_tuser;
            item_reg.trial_passed <= s_tdata[0];
            item_reg.phase_value  <= s_tdata[3:1];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/spt_window.sv @@
// Window search over the eight-phase pass map: wide (five) then narrow (three).
// Depends on spt_pkg for masks and the result type.
`timescale 1ns / 1ps

module spt_window
    import spt_pkg::*;
(
    input  logic [PHASE_COUNT-1:0] pass_map,
    output window_t                pick
);

    logic [2*PHASE_COUNT-1:0] map_dbl;
    logic [PHASE_COUNT-1:0]   wide_hit;
    logic [PHASE_COUNT-1:0]   narrow_hit;
    logic [PHASE_COUNT-1:0]   rot;

    assign map_dbl = {pass_map, pass_map};

    // Test every rotation against both window masks
    always_comb
    begin
        wide_hit   = '0;
        narrow_hit = '0;
        rot        = '0;
        for (int i = 0; i < PHASE_COUNT; i++)
        begin
            rot           = map_dbl[i +: PHASE_COUNT];
            wide_hit[i]   = ((rot & WIDE_WINDOW) == WIDE_WINDOW);
            narrow_hit[i] = ((rot & NARROW_WINDOW) == NARROW_WINDOW);
        end
    end

    // Take the lowest wide hit, else the lowest narrow hit
    always_comb
    begin
        pick.found = 1'b0;
        pick.phase = '0;
        for (int i = PHASE_COUNT - 1; i >= 0; i--)
        begin
            if (narrow_hit[i])
            begin
                pick.found = 1'b1;
                pick.phase = PHASE_W'(i);
            end
        end
        if (|wide_hit)
        begin
            for (int i = PHASE_COUNT - 1; i >= 0; i--)
            begin
                if (wide_hit[i])
                begin
                    pick.phase = PHASE_W'(i);
                end
            end
        end
    end

endmodule

@@ rtl/sample_phase_tuning_sweep_unit.sv @@
// Top level of the sample-phase tuning sweep unit: sweep state and result register.
// Depends on spt_pkg, spt_in_stage and spt_window.
//
//  channel   | direction | tdata                                        | tuser | tlast
//  s_* input | in        | [0] trial_passed, [3:1] phase_value          | kind  | -
//  m_* out   | out       | [2:0] sample_phase, [3] sweep_failed, [11:4] pass_map | -  | sweep_done
//
// An input transaction passes the input register, then the sweep update and window
// search into the result register. One item per cycle is taken while m_tready does
// not stall; the rate is set by the combinational state update path through the window
// search. Reset clears phase, start phase, pass map and the sweeping flag at once.
// A stalled m_tready holds the result and fills the input register before s_tready drops.
`timescale 1ns / 1ps

module sample_phase_tuning_sweep_unit
    import spt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] trial_passed, [3:1] phase_value, [7:4] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] sample_phase, [3] sweep_failed,
                                   // [11:4] pass_map, [15:12] zero
    output logic        m_tlast    // sweep_done
);

    logic                   item_valid;
    item_t                  item;
    logic                   out_free;
    logic                   take;
    window_t                pick;

    logic [PHASE_W-1:0]     phase_now_reg,   phase_now_next;
    logic [PHASE_W-1:0]     start_phase_reg, start_phase_next;
    logic [PHASE_COUNT-1:0] pass_map_reg,    pass_map_next;
    logic                   sweeping_reg,    sweeping_next;
    logic [PHASE_COUNT-1:0] map_trial;
    logic                   done_next;
    logic                   failed_next;

    logic                   out_valid_reg,   out_valid_next;
    logic [PHASE_W-1:0]     out_phase_reg;
    logic                   out_done_reg;
    logic                   out_failed_reg;
    logic [PHASE_COUNT-1:0] out_map_reg;

    // Result register frees up when empty or drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    assign take     = item_valid && out_free;

    spt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .out_free   (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    // Pass map with the current trial folded in
    assign map_trial = pass_map_reg |
                       (item.trial_passed ? (PHASE_COUNT'(1) << phase_now_reg) : '0);

    spt_window u_window (
        .pass_map (map_trial),
        .pick     (pick)
    );

    // Advance the sweep state for the registered item
    always_comb
    begin
        phase_now_next   = phase_now_reg;
        start_phase_next = start_phase_reg;
        pass_map_next    = pass_map_reg;
        sweeping_next    = sweeping_reg;
        done_next        = 1'b0;
        failed_next      = 1'b0;
        case (kind_t'(item.kind))
            KIND_BEGIN:
            begin
                start_phase_next = phase_now_reg;
                pass_map_next    = '0;
                phase_now_next   = phase_now_reg + PHASE_W'(1);
                sweeping_next    = 1'b1;
            end
            KIND_TRIAL:
            begin
                if (sweeping_reg)
                begin
                    pass_map_next = map_trial;
                    if (phase_now_reg == start_phase_reg)
                    begin
                        done_next     = 1'b1;
                        sweeping_next = 1'b0;
                        if (pick.found)
                        begin
                            phase_now_next = pick.phase;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_now_next = phase_now_reg + PHASE_W'(1);
                    end
                end
            end
            KIND_SET:
            begin
                phase_now_next = item.phase_value;
                sweeping_next  = 1'b0;
            end
            default:
            begin
                sweeping_next = sweeping_reg;
            end
        endcase
    end

    // Hold sweep state; update only when an item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_now_reg   <= '0;
            start_phase_reg <= '0;
            pass_map_reg    <= '0;
            sweeping_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_now_reg   <= phase_now_next;
            start_phase_reg <= start_phase_next;
            pass_map_reg    <= pass_map_next;
            sweeping_reg    <= sweeping_next;
        end
    end

    // Result valid flag
    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_phase_reg  <= phase_now_next;
            out_done_reg   <= done_next;
            out_failed_reg <= failed_next;
            out_map_reg    <= pass_map_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {4'b0000, out_map_reg, out_failed_reg, out_phase_reg};

    // A failure is only ever flagged on the transaction that ends a sweep
    a_failed_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_failed_reg |-> out_done_reg)
        else $error("sweep_failed without sweep_done");

    // A chosen window is centred on a passing phase
    a_pick_passes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg && !out_failed_reg |-> out_map_reg[out_phase_reg])
        else $error("selected phase did not pass");

    // A begin item starts a sweep with an empty map
    a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.kind == KIND_BEGIN |=> sweeping_reg && pass_map_reg == '0)
        else $error("begin did not start a clean sweep");

    // A trial outside a sweep leaves phase and map alone
    a_idle_trial: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.kind == KIND_TRIAL && !sweeping_reg |=>
        $stable(phase_now_reg) && $stable(pass_map_reg))
        else $error("idle trial changed state");

endmodule
